// ===== hdl/lgw_pkg.sv =====
// lgw_pkg: shared types for the display window writer
// operation codes, input word and result word layouts
// no dependencies
package lgw_pkg;

    localparam int CoordW = 16;
    localparam int ColorW = 16;
    localparam int OpW    = 3;
    localparam int CodeW  = 8;

    typedef enum logic [OpW-1:0] {
        OP_CMD    = 3'd0,
        OP_DATA   = 3'd1,
        OP_WINDOW = 3'd2,
        OP_CURSOR = 3'd3,
        OP_PIXEL  = 3'd4
    } op_t;

    typedef struct packed {
        logic [OpW-1:0]    cmd;
        logic [CodeW-1:0]  cmd_code;
        logic [CoordW-1:0] in_x;
        logic [CoordW-1:0] in_y;
        logic [CoordW-1:0] win_width;
        logic [CoordW-1:0] win_height;
        logic [ColorW-1:0] pixel_value;
    } item_t;

    typedef struct packed {
        logic              pixel_valid;
        logic [CoordW-1:0] pixel_x;
        logic [CoordW-1:0] pixel_y;
        logic [ColorW-1:0] pixel_color;
    } result_t;

    typedef struct packed {
        logic advance;
        logic out_ready;
    } flow_t;

endpackage

// ===== hdl/lcd_gram_window_writer.sv =====
// lcd_gram_window_writer: top level of the display memory write path
// depends on lgw_pkg, lgw_in_stage, lgw_core, lgw_out_stage
//
// Takes one operation word per clock while the output is not stalled and returns
// exactly one result word for each. The cursor, window and write mode update in
// lgw_core, so words may follow back to back; the input and result registers let
// a new word be taken while a finished result waits. Results with no pixel written
// carry all zeros.
module lcd_gram_window_writer
    import lgw_pkg::*;
#(
    parameter int PANEL_WIDTH    = 240,
    parameter int PANEL_HEIGHT   = 320,
    parameter int MEM_WRITE_CODE = 44
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,  // cmd_code, in_x, in_y, win_width, win_height, pixel_value
    input  logic [2:0]  s_tuser,  // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // pixel_x, pixel_y, pixel_color
    output logic [0:0]  m_tuser   // pixel_valid
);

    item_t   s_item;
    item_t   item;
    flow_t   flow;
    result_t result;
    result_t m_result;
    logic    out_ready;

    assign s_item.cmd         = s_tuser;
    assign s_item.cmd_code    = s_tdata[7:0];
    assign s_item.in_x        = s_tdata[23:8];
    assign s_item.in_y        = s_tdata[39:24];
    assign s_item.win_width   = s_tdata[55:40];
    assign s_item.win_height  = s_tdata[71:56];
    assign s_item.pixel_value = s_tdata[87:72];

    lgw_in_stage u_in
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_item    (s_item),
        .out_ready (out_ready),
        .flow      (flow),
        .item      (item)
    );

    lgw_core #(
        .PANEL_WIDTH    (PANEL_WIDTH),
        .PANEL_HEIGHT   (PANEL_HEIGHT),
        .MEM_WRITE_CODE (MEM_WRITE_CODE)
    ) u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .flow   (flow),
        .item   (item),
        .result (result)
    );

    lgw_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .flow      (flow),
        .result    (result),
        .out_ready (out_ready),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_result  (m_result)
    );

    assign m_tdata = {m_result.pixel_color, m_result.pixel_y, m_result.pixel_x};
    assign m_tuser = m_result.pixel_valid;

endmodule

// ===== hdl/lgw_in_stage.sv =====
// lgw_in_stage: input register for operation words
// depends on lgw_pkg
module lgw_in_stage
    import lgw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    input  logic  out_ready,
    output flow_t flow,
    output item_t item
);

    logic  in_valid_reg;
    logic  in_valid_next;
    item_t item_reg;
    logic  advance;

    assign advance       = in_valid_reg && out_ready;
    assign s_ready       = !in_valid_reg || advance;
    assign in_valid_next = (s_valid && s_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

    assign flow.advance   = advance;
    assign flow.out_ready = out_ready;
    assign item           = item_reg;

endmodule

// ===== hdl/lgw_core.sv =====
// lgw_core: cursor, window and write mode state with the per-word update
// depends on lgw_pkg
module lgw_core
    import lgw_pkg::*;
#(
    parameter int PANEL_WIDTH    = 240,
    parameter int PANEL_HEIGHT   = 320,
    parameter int MEM_WRITE_CODE = 44
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  flow_t   flow,
    input  item_t   item,
    output result_t result
);

    localparam logic [CoordW:0]   PanelW = (CoordW+1)'(PANEL_WIDTH);
    localparam logic [CoordW:0]   PanelH = (CoordW+1)'(PANEL_HEIGHT);
    localparam logic [CodeW-1:0]  MemWr  = CodeW'(MEM_WRITE_CODE);

    logic [CoordW-1:0] col_reg, col_next;
    logic [CoordW-1:0] row_reg, row_next;
    logic [CoordW-1:0] left_reg, left_next;
    logic [CoordW-1:0] top_reg, top_next;
    logic [CoordW-1:0] right_reg, right_next;
    logic [CoordW-1:0] bottom_reg, bottom_next;
    logic              mode_reg, mode_next;

    always_comb
    begin
        logic [CoordW:0]   xe;
        logic [CoordW:0]   ye;
        logic [CoordW-1:0] xc;
        logic [CoordW-1:0] yc;
        logic [CoordW-1:0] ccol;
        logic [CoordW-1:0] crow;
        logic [CoordW-1:0] col1;
        logic [CoordW-1:0] row1;
        logic              on_panel;
        logic              emit;

        col_next    = col_reg;
        row_next    = row_reg;
        left_next   = left_reg;
        top_next    = top_reg;
        right_next  = right_reg;
        bottom_next = bottom_reg;
        mode_next   = mode_reg;
        result      = '0;
        emit        = 1'b0;

        xe = {1'b0, item.in_x} + {1'b0, item.win_width};
        ye = {1'b0, item.in_y} + {1'b0, item.win_height};
        if (xe > PanelW)
        begin
            xe = PanelW;
        end
        if (ye > PanelH)
        begin
            ye = PanelH;
        end
        xc = ({1'b0, item.in_x} > PanelW) ? PanelW[CoordW-1:0] : item.in_x;
        yc = ({1'b0, item.in_y} > PanelH) ? PanelH[CoordW-1:0] : item.in_y;

        on_panel = ({1'b0, item.in_x} < PanelW) && ({1'b0, item.in_y} < PanelH);
        ccol = on_panel ? item.in_x : col_reg;
        crow = on_panel ? item.in_y : row_reg;

        case (op_t'(item.cmd))
            OP_CMD:
            begin
                mode_next = (item.cmd_code == MemWr);
            end
            OP_DATA:
            begin
                ccol = col_reg;
                crow = row_reg;
                emit = mode_reg;
            end
            OP_WINDOW:
            begin
                left_next   = xc;
                top_next    = yc;
                right_next  = xe[CoordW-1:0];
                bottom_next = ye[CoordW-1:0];
                if (({1'b0, xc} < PanelW) && ({1'b0, yc} < PanelH))
                begin
                    col_next = xc;
                    row_next = yc;
                end
            end
            OP_CURSOR:
            begin
                col_next = ccol;
                row_next = crow;
            end
            OP_PIXEL:
            begin
                mode_next = 1'b1;
                emit      = 1'b1;
            end
            default:
            begin
            end
        endcase

        // advance the cursor inside the window after a write
        col1 = ccol + 1'b1;
        row1 = crow + 1'b1;
        if (emit)
        begin
            result.pixel_valid = 1'b1;
            result.pixel_x     = ccol;
            result.pixel_y     = crow;
            result.pixel_color = item.pixel_value;
            if (col1 >= right_reg)
            begin
                col_next = left_reg;
                row_next = (row1 >= bottom_reg) ? top_reg : row1;
            end
            else
            begin
                col_next = col1;
                row_next = crow;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
            mode_reg   <= 1'b0;
        end
        else if (flow.advance)
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            left_reg   <= left_next;
            top_reg    <= top_next;
            right_reg  <= right_next;
            bottom_reg <= bottom_next;
            mode_reg   <= mode_next;
        end
    end

endmodule

// ===== hdl/lgw_out_stage.sv =====
// lgw_out_stage: result register toward the output stream
// depends on lgw_pkg
module lgw_out_stage
    import lgw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  flow_t   flow,
    input  result_t result,
    output logic    out_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;

    assign out_ready      = !out_valid_reg || m_ready;
    assign out_valid_next = flow.advance ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flow.advance && flow.out_ready)
        begin
            result_reg <= result;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = result_reg;

endmodule
